[rtl/vgfv_pkg.sv]
// ----------------------------------------------------------------------------
// vgfv_pkg
// Shared types, constants and the control store of the face visibility core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vgfv_pkg;

	// default volume bounds per axis
	localparam int DEF_MAX_SIZE_X = 64;
	localparam int DEF_MAX_SIZE_Y = 64;
	localparam int DEF_MAX_SIZE_Z = 64;

	localparam int COORD_W   = 6;
	localparam int ID_W      = 8;
	localparam int MASK_W    = 6;
	localparam int SIZE_W    = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET   = 7'd64;
	localparam logic [MASK_W-1:0] MASK_ALL     = 6'd63;
	localparam logic [ID_W-1:0]   ID_AIR       = 8'd0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SIZE_Z = 2'd2;

	// operation codes carried in tuser
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE  = 4'd0;
	localparam step_t ST_CHK   = 4'd1;
	localparam step_t ST_FUNC  = 4'd2;
	localparam step_t ST_AIR   = 4'd3;
	localparam step_t ST_BRD   = 4'd4;
	localparam step_t ST_ZM    = 4'd5;
	localparam step_t ST_YM    = 4'd6;
	localparam step_t ST_XP    = 4'd7;
	localparam step_t ST_YP    = 4'd8;
	localparam step_t ST_XM    = 4'd9;
	localparam step_t ST_LAST  = 4'd10;
	localparam step_t ST_BTOP  = 4'd11;
	localparam step_t ST_BCAP  = 4'd12;
	localparam step_t ST_WR    = 4'd13;
	localparam step_t ST_EMIT  = 4'd14;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_IN_FIRE,
		C_OOR,
		C_WRITE,
		C_AIR,
		C_BORDER,
		C_NO_TOP,
		C_OUT_BUSY
	} cond_t;

	typedef enum logic [2:0] {
		N_CENTER,
		N_ZP,
		N_ZM,
		N_YM,
		N_XP,
		N_YP,
		N_XM
	} nbr_t;

	typedef enum logic [1:0] {
		CAP_NONE,
		CAP_ID,
		CAP_BIT,
		CAP_ALL
	} cap_t;

	typedef struct packed {
		cond_t      cond;
		step_t      t_true;
		step_t      t_false;
		nbr_t       nbr;
		cap_t       cap;
		logic [2:0] cap_bit;
		logic       wr_en;
		logic       emit;
	} ucode_t;

	// effective size: bit 0 dropped, then limited to the axis bound
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
		input logic [8:0] max_size);
		logic [SIZE_W-1:0] even;
		even = raw & 7'h7E;
		if ({2'b00, even} > max_size) begin
			eff_size = max_size[SIZE_W-1:0];
		end else begin
			eff_size = even;
		end
	endfunction

	// control store: one word per step
	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		unique case (pc)
			ST_IDLE: w = '{C_IN_FIRE,  ST_CHK,  ST_IDLE, N_CENTER, CAP_NONE, 3'd0, 1'b0, 1'b0};
			ST_CHK:  w = '{C_OOR,      ST_EMIT, ST_FUNC, N_CENTER, CAP_NONE, 3'd0, 1'b0, 1'b0};
			ST_FUNC: w = '{C_WRITE,    ST_WR,   ST_AIR,  N_CENTER, CAP_ID,   3'd0, 1'b0, 1'b0};
			ST_AIR:  w = '{C_AIR,      ST_EMIT, ST_BRD,  N_CENTER, CAP_NONE, 3'd0, 1'b0, 1'b0};
			ST_BRD:  w = '{C_BORDER,   ST_BTOP, ST_ZM,   N_ZP,     CAP_NONE, 3'd0, 1'b0, 1'b0};
			ST_ZM:   w = '{C_ALWAYS,   ST_YM,   ST_YM,   N_ZM,     CAP_BIT,  3'd0, 1'b0, 1'b0};
			ST_YM:   w = '{C_ALWAYS,   ST_XP,   ST_XP,   N_YM,     CAP_BIT,  3'd1, 1'b0, 1'b0};
			ST_XP:   w = '{C_ALWAYS,   ST_YP,   ST_YP,   N_XP,     CAP_BIT,  3'd2, 1'b0, 1'b0};
			ST_YP:   w = '{C_ALWAYS,   ST_XM,   ST_XM,   N_YP,     CAP_BIT,  3'd3, 1'b0, 1'b0};
			ST_XM:   w = '{C_ALWAYS,   ST_LAST, ST_LAST, N_XM,     CAP_BIT,  3'd4, 1'b0, 1'b0};
			ST_LAST: w = '{C_ALWAYS,   ST_EMIT, ST_EMIT, N_CENTER, CAP_BIT,  3'd5, 1'b0, 1'b0};
			ST_BTOP: w = '{C_NO_TOP,   ST_EMIT, ST_BCAP, N_YP,     CAP_NONE, 3'd0, 1'b0, 1'b0};
			ST_BCAP: w = '{C_ALWAYS,   ST_EMIT, ST_EMIT, N_CENTER, CAP_ALL,  3'd0, 1'b0, 1'b0};
			ST_WR:   w = '{C_ALWAYS,   ST_EMIT, ST_EMIT, N_CENTER, CAP_NONE, 3'd0, 1'b1, 1'b0};
			ST_EMIT: w = '{C_OUT_BUSY, ST_EMIT, ST_IDLE, N_CENTER, CAP_NONE, 3'd0, 1'b0, 1'b1};
			default: w = '{C_ALWAYS,   ST_IDLE, ST_IDLE, N_CENTER, CAP_NONE, 3'd0, 1'b0, 1'b0};
		endcase
		return w;
	endfunction

endpackage

[rtl/voxel_grid_face_visibility_core.sv]
// ----------------------------------------------------------------------------
// voxel_grid_face_visibility_core
// Steps, accept to m_axis_tvalid: range check (out of range: to output), store
// read, then a write, or for a query an air check, a read of the voxel above for
// a world-face voxel or of the six neighbors otherwise, then output, which waits
// while m_axis stalls, before the next item. One store access per sequencer step.
// After reset a clearing pass writes air to all MAX_SIZE_X*MAX_SIZE_Y*MAX_SIZE_Z
// entries, one a cycle, before any item is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_grid_face_visibility_core
	import vgfv_pkg::*;
#(
	parameter int MAX_SIZE_X = DEF_MAX_SIZE_X,
	parameter int MAX_SIZE_Y = DEF_MAX_SIZE_Y,
	parameter int MAX_SIZE_Z = DEF_MAX_SIZE_Z
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// coord_x, coord_y, coord_z, block_id, zero pad
	input  logic [31:0]          s_axis_tdata,
	// func
	input  logic                 s_axis_tuser,

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// face_mask, stored_id, zero pad
	output logic [15:0]          m_axis_tdata,
	// out_of_range
	output logic                 m_axis_tuser,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	localparam int DEPTH = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [AW-1:0] STRIDE_Y  = AW'(MAX_SIZE_X);
	localparam logic [AW-1:0] STRIDE_Z  = AW'(MAX_SIZE_X * MAX_SIZE_Y);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [8:0]    MAX_X9    = 9'(MAX_SIZE_X);
	localparam logic [8:0]    MAX_Y9    = 9'(MAX_SIZE_Y);
	localparam logic [8:0]    MAX_Z9    = 9'(MAX_SIZE_Z);

	logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
	logic [SIZE_W-1:0]  sx, sy, sz;

	logic               clr_busy_q;
	logic [AW-1:0]      clr_addr_q;

	step_t              pc_q;
	ucode_t             uc;
	logic               cond_hit;
	logic               s_fire;
	logic               out_busy;

	logic [COORD_W-1:0] x_q, y_q, z_q;
	logic [ID_W-1:0]    in_id_q;
	logic               func_q;
	logic               oor_q;
	logic [ID_W-1:0]    res_id_q;
	logic [MASK_W-1:0]  mask_q;

	logic [SIZE_W-1:0]  nx, ny, nz;
	logic [AW-1:0]      seq_addr;
	logic [AW-1:0]      mem_addr;
	logic               mem_we;
	logic [ID_W-1:0]    mem_wdata;
	logic [ID_W-1:0]    rd_q;
	logic [ID_W-1:0]    voxel_mem [DEPTH];

	logic               in_oor;
	logic               border;
	logic               no_top;

	logic               out_valid_q;
	logic [MASK_W-1:0]  out_mask_q;
	logic [ID_W-1:0]    out_id_q;
	logic               out_oor_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WORLD_SIZE_X: size_x_q <= cfg_data;
				CFG_WORLD_SIZE_Y: size_y_q <= cfg_data;
				CFG_WORLD_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sx = eff_size(size_x_q, MAX_X9);
	assign sy = eff_size(size_y_q, MAX_Y9);
	assign sz = eff_size(size_z_q, MAX_Z9);

	// sequencer
	assign uc            = ucode_rom(pc_q);
	assign s_axis_tready = !clr_busy_q && (pc_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_busy      = out_valid_q && !m_axis_tready;

	assign in_oor = ({1'b0, s_axis_tdata[5:0]}   >= sx) ||
	                ({1'b0, s_axis_tdata[11:6]}  >= sy) ||
	                ({1'b0, s_axis_tdata[17:12]} >= sz);

	assign border = (x_q == '0) || ({1'b0, x_q} == sx - 7'd1) ||
	                (y_q == '0) || ({1'b0, y_q} == sy - 7'd1) ||
	                (z_q == '0) || ({1'b0, z_q} == sz - 7'd1);
	assign no_top = ({1'b0, y_q} + 7'd1) >= sy;

	always_comb begin
		unique case (uc.cond)
			C_ALWAYS:   cond_hit = 1'b1;
			C_IN_FIRE:  cond_hit = s_fire;
			C_OOR:      cond_hit = oor_q;
			C_WRITE:    cond_hit = (func_q == FUNC_WRITE);
			C_AIR:      cond_hit = (res_id_q == ID_AIR);
			C_BORDER:   cond_hit = border;
			C_NO_TOP:   cond_hit = no_top;
			C_OUT_BUSY: cond_hit = out_busy;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= cond_hit ? uc.t_true : uc.t_false;
		end
	end

	// item registers and result capture
	always_ff @(posedge clk) begin
		if (s_fire) begin
			x_q      <= s_axis_tdata[5:0];
			y_q      <= s_axis_tdata[11:6];
			z_q      <= s_axis_tdata[17:12];
			in_id_q  <= s_axis_tdata[25:18];
			func_q   <= s_axis_tuser;
			oor_q    <= in_oor;
			res_id_q <= ID_AIR;
			mask_q   <= '0;
		end else begin
			if (uc.wr_en) begin
				res_id_q <= in_id_q;
			end
			unique case (uc.cap)
				CAP_NONE: ;
				CAP_ID:   res_id_q <= rd_q;
				CAP_BIT:  mask_q[uc.cap_bit] <= (rd_q == ID_AIR);
				CAP_ALL:  mask_q <= (rd_q == ID_AIR) ? MASK_ALL : '0;
			endcase
		end
	end

	// neighbor address
	always_comb begin
		nx = {1'b0, x_q};
		ny = {1'b0, y_q};
		nz = {1'b0, z_q};
		unique case (uc.nbr)
			N_ZP:    nz = {1'b0, z_q} + 7'd1;
			N_ZM:    nz = {1'b0, z_q} - 7'd1;
			N_YM:    ny = {1'b0, y_q} - 7'd1;
			N_XP:    nx = {1'b0, x_q} + 7'd1;
			N_YP:    ny = {1'b0, y_q} + 7'd1;
			N_XM:    nx = {1'b0, x_q} - 7'd1;
			default: ;
		endcase
	end

	assign seq_addr = AW'(nx) + STRIDE_Y * AW'(ny) + STRIDE_Z * AW'(nz);

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign mem_addr  = clr_busy_q ? clr_addr_q : seq_addr;
	assign mem_we    = clr_busy_q || uc.wr_en;
	assign mem_wdata = clr_busy_q ? ID_AIR : in_id_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			voxel_mem[mem_addr] <= mem_wdata;
		end
		rd_q <= voxel_mem[mem_addr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uc.emit && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.emit && !out_busy) begin
			out_mask_q <= mask_q;
			out_id_q   <= res_id_q;
			out_oor_q  <= oor_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_id_q, out_mask_q};
	assign m_axis_tuser  = out_oor_q;

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_axis_tready)
		else $error("item accepted during clearing pass");

	a_no_store_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		uc.wr_en |-> !clr_busy_q)
		else $error("store write issued during clearing pass");

	a_accept_starts_prog: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (pc_q == ST_CHK))
		else $error("accepted item did not start the program");

	a_oor_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[13:0] == 14'd0))
		else $error("out of range result carries data");
`endif

endmodule

[verif/voxel_grid_face_visibility_core_tb.sv]
// ----------------------------------------------------------------------------
// voxel_grid_face_visibility_core_tb
// Self-checking bench for the face visibility core. A scoreboard keeps its own
// copy of the voxel volume and the size registers, predicts id, face mask and
// range flag for every accepted item, and compares each returned result in
// order. Directed items come first, then clustered random traffic under
// several world sizes, with stalls on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_grid_face_visibility_core_tb;
	import vgfv_pkg::*;

	localparam int VOLUME_DEPTH = DEF_MAX_SIZE_X * DEF_MAX_SIZE_Y * DEF_MAX_SIZE_Z;
	// the clearing pass after reset writes all VOLUME_DEPTH entries with no transfers
	localparam int WATCHDOG_LIMIT = 4 * VOLUME_DEPTH;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct {
		logic [MASK_W-1:0] mask;
		logic [ID_W-1:0]   id;
		logic              oor;
	} voxel_result_t;

	class voxel_scoreboard;
		bit [ID_W-1:0]   grid [VOLUME_DEPTH];
		bit [SIZE_W-1:0] size_x;
		bit [SIZE_W-1:0] size_y;
		bit [SIZE_W-1:0] size_z;
		voxel_result_t   pending_q[$];
		int              errors;

		function new();
			size_x = SIZE_RESET;
			size_y = SIZE_RESET;
			size_z = SIZE_RESET;
			errors = 0;
		endfunction

		// odd sizes lose bit 0, large ones saturate at the axis bound
		function int axis_len(bit [SIZE_W-1:0] raw, int limit);
			int len;
			len = raw & 7'h7E;
			return (len > limit) ? limit : len;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
			case (idx)
				CFG_WORLD_SIZE_X: size_x = data;
				CFG_WORLD_SIZE_Y: size_y = data;
				CFG_WORLD_SIZE_Z: size_z = data;
				default: ;
			endcase
		endfunction

		function bit occupied(int x, int y, int z);
			return grid[x + DEF_MAX_SIZE_X * (y + DEF_MAX_SIZE_Y * z)] != ID_AIR;
		endfunction

		function void note_input(logic func, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
			logic [COORD_W-1:0] cz, logic [ID_W-1:0] id);
			voxel_result_t r;
			int sx, sy, sz, x, y, z, a;
			sx = axis_len(size_x, DEF_MAX_SIZE_X);
			sy = axis_len(size_y, DEF_MAX_SIZE_Y);
			sz = axis_len(size_z, DEF_MAX_SIZE_Z);
			x = cx;
			y = cy;
			z = cz;
			r.mask = '0;
			r.id = ID_AIR;
			r.oor = 1'b0;
			if (x >= sx || y >= sy || z >= sz) begin
				r.oor = 1'b1;
			end else begin
				a = x + DEF_MAX_SIZE_X * (y + DEF_MAX_SIZE_Y * z);
				if (func == FUNC_WRITE) begin
					grid[a] = id;
					r.id = id;
				end else begin
					r.id = grid[a];
					if (r.id != ID_AIR) begin
						if (x == 0 || x == sx - 1 || y == 0 || y == sy - 1 ||
							z == 0 || z == sz - 1) begin
							// world face: all or nothing, decided by the voxel above
							if (y + 1 < sy && !occupied(x, y + 1, z))
								r.mask = MASK_ALL;
						end else begin
							r.mask[0] = !occupied(x, y, z + 1);
							r.mask[1] = !occupied(x, y, z - 1);
							r.mask[2] = !occupied(x, y - 1, z);
							r.mask[3] = !occupied(x + 1, y, z);
							r.mask[4] = !occupied(x, y + 1, z);
							r.mask[5] = !occupied(x - 1, y, z);
						end
					end
				end
			end
			pending_q.insert(pending_q.size(), r);
		endfunction

		task report(string field, int got, int want);
			$display("mismatch %s: got %0d, want %0d at %0t", field, got, want, $realtime);
			errors++;
		endtask

		task check_result(logic [MASK_W-1:0] mask, logic [ID_W-1:0] id, logic oor);
			voxel_result_t w;
			if (pending_q.size() == 0) begin
				report("unexpected result, face_mask", mask, -1);
			end else begin
				w = pending_q.pop_front();
				if (mask !== w.mask)
					report("face_mask", mask, w.mask);
				if (id !== w.id)
					report("stored_id", id, w.id);
				if (oor !== w.oor)
					report("out_of_range", oor, w.oor);
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;

	voxel_scoreboard sb = new();
	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int quiet_cycles = 0;

	voxel_grid_face_visibility_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// every transfer is sampled here, on the edge where it happens
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata[5:0], m_axis_tdata[13:6], m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[11:6],
					s_axis_tdata[17:12], s_axis_tdata[25:18]);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task send_item(logic func, int x, int y, int z, int id);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {6'b0, id[ID_W-1:0], z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drain all results, then leave room for the longest sequence
	task settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task apply_sizes(int sx, int sy, int sz);
		write_cfg(CFG_WORLD_SIZE_X, sx[SIZE_W-1:0]);
		write_cfg(CFG_WORLD_SIZE_Y, sy[SIZE_W-1:0]);
		write_cfg(CFG_WORLD_SIZE_Z, sz[SIZE_W-1:0]);
	endtask

	// mostly inside a small cluster so neighbors fill in, some anywhere, some edges
	function automatic int pick_coord(int len, int base);
		int r, c;
		r = $urandom_range(99);
		if (len > 0 && r < 80) begin
			c = base + $urandom_range(3);
			if (c > len - 1)
				c = len - 1;
		end else if (r < 90 || len == 0) begin
			c = $urandom_range(63);
		end else begin
			case ($urandom_range(2))
				0: c = 0;
				1: c = len - 1;
				default: c = len;
			endcase
		end
		return c & 63;
	endfunction

	task run_random(int count);
		int lx, ly, lz, bx, by, bz, r, id;
		logic func;
		lx = sb.axis_len(sb.size_x, DEF_MAX_SIZE_X);
		ly = sb.axis_len(sb.size_y, DEF_MAX_SIZE_Y);
		lz = sb.axis_len(sb.size_z, DEF_MAX_SIZE_Z);
		for (int i = 0; i < count; i++) begin
			if (i % 48 == 0) begin
				bx = (lx > 4) ? $urandom_range(lx - 4) : 0;
				by = (ly > 4) ? $urandom_range(ly - 4) : 0;
				bz = (lz > 4) ? $urandom_range(lz - 4) : 0;
			end
			if (items_sent < 540) begin
				send_idle_pct = 6;
				recv_idle_pct = 78;
			end else if (items_sent < 1060) begin
				send_idle_pct = 78;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			r = $urandom_range(99);
			if (r < 30)
				id = ID_AIR;
			else if (r < 35)
				id = 255;
			else
				id = $urandom_range(255, 1);
			func = $urandom_range(1) ? FUNC_QUERY : FUNC_WRITE;
			send_item(func, pick_coord(lx, bx), pick_coord(ly, by), pick_coord(lz, bz), id);
		end
		settle();
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= FUNC_WRITE;
		cfg_valid     <= 1'b0;
		cfg_index     <= CFG_WORLD_SIZE_X;
		cfg_data      <= SIZE_RESET;
		send_idle_pct = 6;
		recv_idle_pct = 78;
		items_sent    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: air, corners, interior masks, world faces, field extremes
		send_item(FUNC_QUERY, 0, 0, 0, 0);
		send_item(FUNC_WRITE, 63, 63, 63, 255);
		send_item(FUNC_QUERY, 63, 63, 63, 0);
		send_item(FUNC_WRITE, 10, 10, 10, 5);
		send_item(FUNC_QUERY, 10, 10, 10, 255);
		send_item(FUNC_WRITE, 10, 11, 10, 1);
		send_item(FUNC_WRITE, 10, 10, 11, 2);
		send_item(FUNC_QUERY, 10, 10, 10, 0);
		send_item(FUNC_WRITE, 9, 10, 10, 3);
		send_item(FUNC_WRITE, 11, 10, 10, 4);
		send_item(FUNC_WRITE, 10, 9, 10, 6);
		send_item(FUNC_WRITE, 10, 10, 9, 128);
		send_item(FUNC_QUERY, 10, 10, 10, 0);
		send_item(FUNC_WRITE, 0, 5, 5, 7);
		send_item(FUNC_QUERY, 0, 5, 5, 0);
		send_item(FUNC_WRITE, 0, 6, 5, 8);
		send_item(FUNC_QUERY, 0, 5, 5, 0);
		send_item(FUNC_WRITE, 10, 10, 10, 0);
		send_item(FUNC_QUERY, 10, 10, 10, 0);
		settle();

		// odd, saturating and undersized registers
		apply_sizes(3, 127, 11);
		send_item(FUNC_WRITE, 2, 0, 0, 9);
		send_item(FUNC_QUERY, 1, 5, 10, 0);
		send_item(FUNC_WRITE, 1, 63, 9, 9);
		send_item(FUNC_QUERY, 1, 63, 9, 0);
		settle();
		write_cfg(CFG_WORLD_SIZE_X, 7'd1);
		send_item(FUNC_QUERY, 0, 0, 0, 0);
		settle();

		apply_sizes(64, 64, 64);
		run_random(300);
		apply_sizes(2, 2, 2);
		run_random(150);
		apply_sizes(8, 6, 10);
		write_cfg(CFG_UNUSED_IDX, SIZE_W'($urandom_range(127)));
		run_random(250);
		apply_sizes(127, 65, 33);
		run_random(250);
		apply_sizes(0, 64, 1);
		run_random(40);
		apply_sizes(16, 16, 16);
		run_random(260);
		apply_sizes(3, 5, 7);
		run_random(150);
		apply_sizes(64, 64, 64);
		run_random(150);

		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
rtl/vgfv_pkg.sv
rtl/voxel_grid_face_visibility_core.sv
verif/voxel_grid_face_visibility_core_tb.sv
